// ----- rtl/i2cmra_pkg.sv -----
// Shared types and constants for the I2C register access master.
package i2cmra_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_TICKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 2'd1;

    // Configuration reset values
    localparam logic [7:0] PHASE_TICKS_RST = 8'd1;
    localparam logic [7:0] ACK_TIMEOUT_RST = 8'd200;

    // Command codes
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;
    localparam logic [1:0] CMD_BYTE  = 2'd3;

    // Read/write bit appended to the device address
    localparam logic RW_READ = 1'b1;

    typedef struct packed {
        logic [1:0] cmd;
        logic [6:0] dev_addr;
        logic [7:0] reg_addr;
        logic [7:0] length;
        logic [7:0] write_byte;
        logic       sda_in;
    } t_in_item;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive;
        logic [7:0] read_byte;
        logic       read_valid;
        logic       read_last;
        logic       need_byte;
        logic       busy_res;
        logic       done_res;
        logic       ack_error;
    } t_out_item;

    typedef struct packed {
        logic [7:0] phase_ticks;
        logic [7:0] ack_timeout;
    } t_cfg;

endpackage

// ----- rtl/i2cmra_seq.sv -----
// Bus sequencer: advances the I2C transaction by one tick per step.
module i2cmra_seq (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  i2cmra_pkg::t_in_item  i_item,
    input  i2cmra_pkg::t_cfg      i_cfg,
    output i2cmra_pkg::t_out_item o_res
);
    import i2cmra_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_START1, S_TXADW, S_AKADW, S_TXREG, S_AKREG, S_NEEDB, S_TXDAT,
        S_AKDAT, S_START2, S_TXADR, S_AKADR, S_RXBIT, S_MACK, S_STOP
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_phase, n_phase;
    logic [7:0] r_tick, n_tick;
    logic [2:0] r_bit, n_bit;
    logic [7:0] r_left, n_left;
    logic [7:0] r_shift, n_shift;
    logic [7:0] r_poll, n_poll;
    logic [6:0] r_dev, n_dev;
    logic [7:0] r_reg, n_reg;
    logic       r_rd, n_rd;
    logic       r_err, n_err;

    logic       is_ack, is_tx, timed, go;
    t_state     target;
    logic [7:0] pt;
    logic [7:0] shift_in;

    assign is_ack = (r_state == S_AKADW) || (r_state == S_AKREG) ||
                    (r_state == S_AKDAT) || (r_state == S_AKADR);
    assign is_tx  = (r_state == S_TXADW) || (r_state == S_TXREG) ||
                    (r_state == S_TXDAT) || (r_state == S_TXADR);
    assign pt       = (i_cfg.phase_ticks == 8'd0) ? 8'd1 : i_cfg.phase_ticks;
    assign shift_in = {r_shift[6:0], i_item.sda_in};

    // Compute the bus levels for this tick and the next sequencer state
    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_tick  = r_tick;
        n_bit   = r_bit;
        n_left  = r_left;
        n_shift = r_shift;
        n_poll  = r_poll;
        n_dev   = r_dev;
        n_reg   = r_reg;
        n_rd    = r_rd;
        n_err   = r_err;
        go      = 1'b0;
        target  = S_IDLE;
        timed   = 1'b1;

        o_res            = '0;
        o_res.scl_level  = 1'b1;
        o_res.sda_level  = 1'b1;
        o_res.sda_drive  = 1'b1;
        o_res.busy_res   = (r_state != S_IDLE);

        // Drive the bus for the current slot and phase
        if (r_state != S_IDLE && r_state != S_NEEDB) begin
            o_res.scl_level = r_phase[1];
        end
        if (r_state == S_START1 || r_state == S_START2) begin
            o_res.sda_level = (r_phase != 2'd3);
        end else if (r_state == S_STOP) begin
            o_res.sda_level = (r_phase == 2'd3);
        end else if (is_tx) begin
            o_res.sda_level = r_shift[3'd7 - r_bit];
        end else if (r_state == S_NEEDB) begin
            o_res.scl_level = 1'b0;
            o_res.sda_level = 1'b0;
            o_res.need_byte = 1'b1;
        end else if (r_state == S_MACK) begin
            o_res.sda_level = (r_left == 8'd1);
        end else if (is_ack || r_state == S_RXBIT) begin
            o_res.sda_drive = 1'b0;
        end

        // Untimed states: command intake and acknowledge polling
        if (r_state == S_IDLE) begin
            timed = 1'b0;
            if (i_item.cmd == CMD_WRITE || i_item.cmd == CMD_READ) begin
                n_dev  = i_item.dev_addr;
                n_reg  = i_item.reg_addr;
                n_left = i_item.length;
                n_rd   = (i_item.cmd == CMD_READ);
                n_err  = 1'b0;
                go     = 1'b1;
                target = S_START1;
            end
        end else if (r_state == S_NEEDB) begin
            timed = 1'b0;
            if (i_item.cmd == CMD_BYTE) begin
                n_shift = i_item.write_byte;
                go      = 1'b1;
                target  = S_TXDAT;
            end
        end else if (is_ack && r_phase == 2'd2) begin
            timed = 1'b0;
            if (!i_item.sda_in) begin
                n_phase = 2'd3;
                n_tick  = '0;
                n_poll  = '0;
            end else if ({1'b0, r_poll} + 9'd1 > {1'b0, i_cfg.ack_timeout}) begin
                n_err  = 1'b1;
                go     = 1'b1;
                target = S_STOP;
            end else begin
                n_poll = r_poll + 8'd1;
            end
        end

        // Timed phases: count ticks, sample, end slots
        if (timed) begin
            if ({1'b0, r_tick} + 9'd1 >= {1'b0, pt}) begin
                n_tick = '0;
                if (r_state == S_RXBIT && r_phase == 2'd2) begin
                    n_shift = shift_in;
                    if (r_bit == 3'd7) begin
                        o_res.read_valid = 1'b1;
                        o_res.read_byte  = shift_in;
                        o_res.read_last  = (r_left == 8'd1);
                    end
                end
                if (r_phase == 2'd3) begin
                    if ((is_tx || r_state == S_RXBIT) && r_bit != 3'd7) begin
                        n_phase = '0;
                        n_bit   = r_bit + 3'd1;
                    end else begin
                        go = 1'b1;
                        case (r_state)
                            S_START1: begin
                                target  = S_TXADW;
                                n_shift = {r_dev, ~RW_READ};
                            end
                            S_TXADW: target = S_AKADW;
                            S_AKADW: begin
                                target  = S_TXREG;
                                n_shift = r_reg;
                            end
                            S_TXREG: target = S_AKREG;
                            S_AKREG: begin
                                if (r_rd) begin
                                    target = S_START2;
                                end else begin
                                    target = (r_left == 8'd0) ? S_STOP : S_NEEDB;
                                end
                            end
                            S_TXDAT: target = S_AKDAT;
                            S_AKDAT: begin
                                n_left = r_left - 8'd1;
                                target = (r_left == 8'd1) ? S_STOP : S_NEEDB;
                            end
                            S_START2: begin
                                target  = S_TXADR;
                                n_shift = {r_dev, RW_READ};
                            end
                            S_TXADR: target = S_AKADR;
                            S_AKADR: target = (r_left == 8'd0) ? S_STOP : S_RXBIT;
                            S_RXBIT: target = S_MACK;
                            S_MACK: begin
                                n_left = r_left - 8'd1;
                                target = (r_left == 8'd1) ? S_STOP : S_RXBIT;
                            end
                            S_STOP: begin
                                target          = S_IDLE;
                                o_res.done_res  = 1'b1;
                                o_res.ack_error = r_err;
                            end
                            default: target = S_IDLE;
                        endcase
                    end
                end else begin
                    n_phase = r_phase + 2'd1;
                end
            end else begin
                n_tick = r_tick + 8'd1;
            end
        end

        // Enter a new slot with cleared counters
        if (go) begin
            n_state = target;
            n_phase = '0;
            n_tick  = '0;
            n_bit   = '0;
            n_poll  = '0;
        end
    end

    // Hold state between steps, advance on each step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= '0;
            r_tick  <= '0;
            r_bit   <= '0;
            r_left  <= '0;
            r_shift <= '0;
            r_poll  <= '0;
            r_dev   <= '0;
            r_reg   <= '0;
            r_rd    <= 1'b0;
            r_err   <= 1'b0;
        end else if (i_step) begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_tick  <= n_tick;
            r_bit   <= n_bit;
            r_left  <= n_left;
            r_shift <= n_shift;
            r_poll  <= n_poll;
            r_dev   <= n_dev;
            r_reg   <= n_reg;
            r_rd    <= n_rd;
            r_err   <= n_err;
        end
    end

    // A finished transaction returns the sequencer to idle
    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_res.done_res) |=> (r_state == S_IDLE))
        else $error("sequencer did not return to idle after done");

    // An error is only reported together with done
    a_err_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.ack_error |-> (o_res.done_res && o_res.busy_res))
        else $error("ack_error outside of done");

    // While waiting for a write byte the slot counters stay cleared
    a_needb_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NEEDB) |-> (r_phase == 2'd0 && r_tick == 8'd0 && r_bit == 3'd0))
        else $error("slot counters moved while waiting for a byte");

    // A received byte is only reported during a read
    a_read_in_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.read_valid |-> (r_rd && r_state == S_RXBIT))
        else $error("read byte reported outside a read");

endmodule

// ----- rtl/i2c_master_register_access.sv -----
// Top level of the I2C register access master: channels, config and staging.
//
// Usage: each input transaction is one timing tick of the bus sequencer and
// produces exactly one result transaction with the SCL/SDA drive for that
// tick plus read data and status. cmd 1 or 2 starts a write or read at
// dev_addr/reg_addr for length bytes; cmd 3 supplies a write byte while
// need_byte is shown; cmd 0 just advances time.
// Configuration: write phase_ticks (index 0) or ack_timeout (index 1) on the
// config channel while no transaction is pending; it is always ready.
// Path: an accepted input is held in the input register, then its result is
// captured in the result register. Throughput: one transaction per cycle
// when the receiver keeps ready high, set by the sequencer update between them.
// Stall: when the result receiver holds ready low, the result register
// holds, the input register fills, and input ready then drops until the
// result is taken; nothing is lost or repeated.
// Reset: synchronous, active low; the sequencer returns to idle (SCL high,
// SDA driven high), both stages empty, phase_ticks = 1, ack_timeout = 200.
module i2c_master_register_access (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  i2cmra_pkg::t_in_item              i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output i2cmra_pkg::t_out_item             o_out_data,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [i2cmra_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [7:0]                        i_cfg_data
);
    import i2cmra_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;
    t_cfg      r_cfg;
    t_out_item res;
    logic      step;

    // Advance the sequencer when the input stage is full and the result slot frees
    assign step        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || step;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    // Capture configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.phase_ticks <= PHASE_TICKS_RST;
            r_cfg.ack_timeout <= ACK_TIMEOUT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PHASE_TICKS: r_cfg.phase_ticks <= i_cfg_data;
                CFG_ACK_TIMEOUT: r_cfg.ack_timeout <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Hold the accepted input transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // Hold the result until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= res;
        end
    end

    i2cmra_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_item  (r_in),
        .i_cfg   (r_cfg),
        .o_res   (res)
    );

endmodule

// ----- test/tb_i2c_master_register_access.sv -----
// Testbench for the I2C register access master: tick-level bus prediction and checking.
module tb_i2c_master_register_access;
    import i2cmra_pkg::*;

    localparam int HOLD_CYCLES  = 200;
    localparam int RANDOM_ITEMS = 60;
    localparam int PRINT_CAP    = 50;

    // Sequencer phases of an I2C transfer
    typedef enum logic [4:0] {
        SQ_IDLE, SQ_START1, SQ_TXADW, SQ_AKADW, SQ_TXREG, SQ_AKREG, SQ_NEEDB,
        SQ_TXDAT, SQ_AKDAT, SQ_START2, SQ_TXADR, SQ_AKADR, SQ_RXBIT, SQ_MACK,
        SQ_STOP
    } t_seq;

    typedef struct packed {
        t_seq       seq;
        logic [1:0] phase;
        logic [7:0] ticks;
        logic [3:0] bitn;
        logic [7:0] left;
        logic [7:0] shreg;
        logic [7:0] polls;
        logic [6:0] dev;
        logic [7:0] regi;
        logic       rd;
        logic       err;
    } t_bus_state;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    t_in_item             in_data;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    t_out_item            out_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [7:0]           cfg_data;

    // Bus state seen by the checker and by the stimulus planner
    t_bus_state line_state;
    t_cfg       line_cfg;
    t_bus_state plan_state;
    t_cfg       plan_cfg;
    t_out_item  bus_levels_due[$];

    logic steady = 1'b0;
    int   hold_asked = 0;
    int   hold_served = 0;
    int   hold_left = 0;

    int errors = 0;
    int items_sent = 0;
    int results_seen = 0;
    int transfers = 0;
    int bytes_read = 0;
    int aborts = 0;
    int cfg_writes = 0;

    i2c_master_register_access DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic bit waits_for_ack(t_seq s);
        return s == SQ_AKADW || s == SQ_AKREG || s == SQ_AKDAT || s == SQ_AKADR;
    endfunction

    function automatic bit sends_bits(t_seq s);
        return s == SQ_TXADW || s == SQ_TXREG || s == SQ_TXDAT || s == SQ_TXADR;
    endfunction

    function automatic t_bus_state enter_slot(t_bus_state st, t_seq s);
        st.seq   = s;
        st.phase = 2'd0;
        st.ticks = 8'd0;
        st.bitn  = 4'd0;
        st.polls = 8'd0;
        return st;
    endfunction

    // Advance the sequencer by one tick and work out the bus levels it shows
    function automatic t_bus_state i2c_tick(input t_bus_state st, input t_cfg cfg,
                                            input t_in_item it, output t_out_item r);
        t_seq       s;
        logic [1:0] ph;
        logic [7:0] pt;
        bit         timed;
        s     = st.seq;
        ph    = st.phase;
        pt    = (cfg.phase_ticks == 8'd0) ? 8'd1 : cfg.phase_ticks;
        timed = 1'b1;
        r = '0;
        r.scl_level = 1'b1;
        r.sda_level = 1'b1;
        r.sda_drive = 1'b1;
        r.busy_res  = (s != SQ_IDLE);

        // Levels driven on this tick
        if (s != SQ_IDLE && s != SQ_NEEDB) r.scl_level = (ph >= 2'd2);
        if (s == SQ_START1 || s == SQ_START2) begin
            r.sda_level = (ph != 2'd3);
        end else if (s == SQ_STOP) begin
            r.sda_level = (ph == 2'd3);
        end else if (sends_bits(s)) begin
            r.sda_level = st.shreg[3'd7 - st.bitn[2:0]];
        end else if (s == SQ_NEEDB) begin
            r.scl_level = 1'b0;
            r.sda_level = 1'b0;
            r.need_byte = 1'b1;
        end else if (s == SQ_MACK) begin
            r.sda_level = (st.left == 8'd1);
        end else if (waits_for_ack(s) || s == SQ_RXBIT) begin
            r.sda_drive = 1'b0;
        end

        // Commands, byte supply and acknowledge polling
        if (s == SQ_IDLE) begin
            timed = 1'b0;
            if (it.cmd == CMD_WRITE || it.cmd == CMD_READ) begin
                st.dev  = it.dev_addr;
                st.regi = it.reg_addr;
                st.left = it.length;
                st.rd   = (it.cmd == CMD_READ);
                st.err  = 1'b0;
                st = enter_slot(st, SQ_START1);
            end
        end else if (s == SQ_NEEDB) begin
            timed = 1'b0;
            if (it.cmd == CMD_BYTE) begin
                st.shreg = it.write_byte;
                st = enter_slot(st, SQ_TXDAT);
            end
        end else if (waits_for_ack(s) && ph == 2'd2) begin
            timed = 1'b0;
            if (!it.sda_in) begin
                st.phase = 2'd3;
                st.ticks = 8'd0;
                st.polls = 8'd0;
            end else if ({1'b0, st.polls} + 9'd1 > {1'b0, cfg.ack_timeout}) begin
                st.err = 1'b1;
                st = enter_slot(st, SQ_STOP);
            end else begin
                st.polls = st.polls + 8'd1;
            end
        end

        // Timed phases, bit sampling and slot ends
        if (timed) begin
            if ({1'b0, st.ticks} + 9'd1 >= {1'b0, pt}) begin
                st.ticks = 8'd0;
                if (s == SQ_RXBIT && ph == 2'd2) begin
                    st.shreg = {st.shreg[6:0], it.sda_in};
                    if (st.bitn[2:0] == 3'd7) begin
                        r.read_valid = 1'b1;
                        r.read_byte  = st.shreg;
                        r.read_last  = (st.left == 8'd1);
                    end
                end
                if (ph != 2'd3) begin
                    st.phase = ph + 2'd1;
                end else if ((sends_bits(s) || s == SQ_RXBIT) && st.bitn < 4'd7) begin
                    st.phase = 2'd0;
                    st.bitn  = st.bitn + 4'd1;
                end else begin
                    case (s)
                        SQ_START1: begin
                            st = enter_slot(st, SQ_TXADW);
                            st.shreg = {st.dev, ~RW_READ};
                        end
                        SQ_TXADW: st = enter_slot(st, SQ_AKADW);
                        SQ_AKADW: begin
                            st = enter_slot(st, SQ_TXREG);
                            st.shreg = st.regi;
                        end
                        SQ_TXREG: st = enter_slot(st, SQ_AKREG);
                        SQ_AKREG: begin
                            if (st.rd) st = enter_slot(st, SQ_START2);
                            else st = enter_slot(st, st.left == 8'd0 ? SQ_STOP : SQ_NEEDB);
                        end
                        SQ_TXDAT: st = enter_slot(st, SQ_AKDAT);
                        SQ_AKDAT: begin
                            st.left = st.left - 8'd1;
                            st = enter_slot(st, st.left == 8'd0 ? SQ_STOP : SQ_NEEDB);
                        end
                        SQ_START2: begin
                            st = enter_slot(st, SQ_TXADR);
                            st.shreg = {st.dev, RW_READ};
                        end
                        SQ_TXADR: st = enter_slot(st, SQ_AKADR);
                        SQ_AKADR: st = enter_slot(st, st.left == 8'd0 ? SQ_STOP : SQ_RXBIT);
                        SQ_RXBIT: st = enter_slot(st, SQ_MACK);
                        SQ_MACK: begin
                            st.left = st.left - 8'd1;
                            st = enter_slot(st, st.left == 8'd0 ? SQ_STOP : SQ_RXBIT);
                        end
                        SQ_STOP: begin
                            st = enter_slot(st, SQ_IDLE);
                            r.done_res  = 1'b1;
                            r.ack_error = st.err;
                        end
                        default: st = enter_slot(st, SQ_IDLE);
                    endcase
                end
            end else begin
                st.ticks = st.ticks + 8'd1;
            end
        end
        return st;
    endfunction

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            errors++;
            if (errors <= PRINT_CAP)
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    // Predict on each accepted input transaction, compare each result transaction
    always @(posedge clk) begin : scoreboard
        t_out_item due;
        if (!rst_n) begin
            line_state = '0;
            line_cfg   = '{phase_ticks: PHASE_TICKS_RST, ack_timeout: ACK_TIMEOUT_RST};
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_PHASE_TICKS) line_cfg.phase_ticks = cfg_data;
                else if (cfg_index == CFG_ACK_TIMEOUT) line_cfg.ack_timeout = cfg_data;
            end
            if (in_valid && in_ready) begin
                line_state = i2c_tick(line_state, line_cfg, in_data, due);
                bus_levels_due.push_back(due);
            end
            if (out_valid && out_ready) begin
                if (bus_levels_due.size() == 0) begin
                    errors++;
                    if (errors <= PRINT_CAP)
                        $display("%0t: unexpected result, expected none, got %h",
                                 $time, out_data);
                end else begin
                    due = bus_levels_due.pop_front();
                    results_seen++;
                    if (due.read_valid) bytes_read++;
                    if (due.done_res && due.ack_error) aborts++;
                    check_field("scl_level",  8'(due.scl_level),  8'(out_data.scl_level));
                    check_field("sda_level",  8'(due.sda_level),  8'(out_data.sda_level));
                    check_field("sda_drive",  8'(due.sda_drive),  8'(out_data.sda_drive));
                    check_field("read_byte",  due.read_byte,      out_data.read_byte);
                    check_field("read_valid", 8'(due.read_valid), 8'(out_data.read_valid));
                    check_field("read_last",  8'(due.read_last),  8'(out_data.read_last));
                    check_field("need_byte",  8'(due.need_byte),  8'(out_data.need_byte));
                    check_field("busy_res",   8'(due.busy_res),   8'(out_data.busy_res));
                    check_field("done_res",   8'(due.done_res),   8'(out_data.done_res));
                    check_field("ack_error",  8'(due.ack_error),  8'(out_data.ack_error));
                end
            end
        end
    end

    // Drive result ready: random stalls, plus a long hold-off when asked
    always @(posedge clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else if (hold_served != hold_asked) begin
            hold_served <= hold_served + 1;
            hold_left   <= HOLD_CYCLES;
            out_ready   <= 1'b0;
        end else begin
            out_ready <= steady || ($urandom_range(99) >= 32);
        end
    end

    // Offer one input transaction after random gaps and hold it until taken
    task automatic send_item(t_in_item it);
        t_out_item unused;
        while (!steady && $urandom_range(99) < 32) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        if (plan_state.seq == SQ_IDLE && (it.cmd == CMD_WRITE || it.cmd == CMD_READ))
            transfers++;
        plan_state = i2c_tick(plan_state, plan_cfg, it, unused);
        in_valid <= 1'b1;
        in_data  <= it;
        items_sent++;
        do @(posedge clk); while (!in_ready);
    endtask

    // Stop offering and wait until every predicted result has arrived
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (bus_levels_due.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_config(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_PHASE_TICKS) plan_cfg.phase_ticks = val;
        else plan_cfg.ack_timeout = val;
        cfg_writes++;
    endtask

    function automatic t_in_item begin_item(logic [1:0] cmd, logic [6:0] dev,
                                            logic [7:0] regi, logic [7:0] len);
        t_in_item it;
        it.cmd        = cmd;
        it.dev_addr   = dev;
        it.reg_addr   = regi;
        it.length     = len;
        it.write_byte = 8'($urandom);
        it.sda_in     = 1'($urandom);
        return it;
    endfunction

    // Build the next tick as a well-behaved slave and host would, with some noise;
    // a non-negative data_val fixes write bytes and read bits
    function automatic t_in_item tick_item(t_bus_state st, int nack_pct, int data_val);
        t_in_item it;
        it = begin_item(CMD_TICK, 7'($urandom), 8'($urandom), 8'($urandom));
        if (st.seq == SQ_NEEDB) begin
            if ($urandom_range(99) < 75) it.cmd = CMD_BYTE;
            if (data_val >= 0) it.write_byte = 8'(data_val);
        end else if ($urandom_range(99) < 10) begin
            it.cmd = 2'($urandom_range(3));
        end
        if (waits_for_ack(st.seq) && st.phase == 2'd2)
            it.sda_in = ($urandom_range(99) < nack_pct);
        else if (st.seq == SQ_RXBIT && data_val >= 0)
            it.sda_in = data_val[0];
        return it;
    endfunction

    // Send the opening item, then tick until the sequencer is idle again
    task automatic run_transfer(t_in_item first_item, int nack_pct, int data_val);
        send_item(first_item);
        while (plan_state.seq != SQ_IDLE)
            send_item(tick_item(plan_state, nack_pct, data_val));
    endtask

    task automatic test_idle_commands();
        send_item(begin_item(CMD_TICK, 7'h7F, 8'hFF, 8'hFF));
        send_item(begin_item(CMD_BYTE, 7'h00, 8'h00, 8'h00));
        send_item(begin_item(CMD_TICK, 7'h00, 8'h00, 8'h00));
    endtask

    task automatic test_write();
        // begin while busy must be ignored
        send_item(begin_item(CMD_WRITE, 7'h7F, 8'hFF, 8'd1));
        send_item(begin_item(CMD_READ, 7'h00, 8'h00, 8'd9));
        run_transfer(begin_item(CMD_TICK, 7'h00, 8'h00, 8'd0), 0, 255);
    endtask

    task automatic test_read();
        run_transfer(begin_item(CMD_READ, 7'h55, 8'hAA, 8'd2), 0, 255);
    endtask

    task automatic test_ack_timeout();
        set_config(CFG_ACK_TIMEOUT, 8'd1);
        run_transfer(begin_item(CMD_READ, 7'h2A, 8'h55, 8'hFF), 100, -1);
        set_config(CFG_ACK_TIMEOUT, 8'd255);
        run_transfer(begin_item(CMD_WRITE, 7'h6A, 8'h81, 8'd1), 100, -1);
    endtask

    task automatic test_phase_ticks();
        set_config(CFG_PHASE_TICKS, 8'd0);
        run_transfer(begin_item(CMD_READ, 7'h00, 8'hFF, 8'd0), 0, -1);
        // Run part of a transfer at the slowest rate, then finish it faster
        set_config(CFG_PHASE_TICKS, 8'd255);
        send_item(begin_item(CMD_WRITE, 7'h12, 8'h34, 8'd0));
        repeat (40) send_item(tick_item(plan_state, 0, -1));
        set_config(CFG_PHASE_TICKS, 8'd1);
        run_transfer(begin_item(CMD_TICK, 7'h00, 8'h00, 8'd0), 0, -1);
    endtask

    task automatic test_full_rate();
        steady <= 1'b1;
        run_transfer(begin_item(CMD_WRITE, 7'h5A, 8'hC3, 8'd1), 0, -1);
        steady <= 1'b0;
    endtask

    task automatic test_backpressure();
        hold_asked <= hold_asked + 1;
        run_transfer(begin_item(CMD_READ, 7'h63, 8'h9C, 8'd0), 0, -1);
    endtask

    task automatic test_random();
        int start;
        int nack_pct;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS) begin
            // Occasionally retune between transfers
            if ($urandom_range(99) < 25) begin
                if ($urandom_range(1) == 0)
                    set_config(CFG_PHASE_TICKS, 8'($urandom_range(1, 4)));
                else
                    set_config(CFG_ACK_TIMEOUT,
                               ($urandom_range(9) == 0) ? 8'd255 : 8'($urandom_range(1, 6)));
            end
            // Idle noise that the block ignores
            if ($urandom_range(99) < 20) begin
                repeat ($urandom_range(1, 3))
                    send_item(begin_item($urandom_range(1) ? CMD_BYTE : CMD_TICK,
                                         7'($urandom), 8'($urandom), 8'($urandom)));
            end
            nack_pct = ($urandom_range(99) < 80) ? 20 : 70;
            run_transfer(begin_item($urandom_range(1) ? CMD_READ : CMD_WRITE,
                                    7'($urandom), 8'($urandom),
                                    ($urandom_range(99) < 80) ? 8'($urandom_range(3))
                                                              : 8'($urandom_range(4, 8))),
                         nack_pct, -1);
        end
    endtask

    initial begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_PHASE_TICKS;
        cfg_data  = 8'd0;
        plan_state = '0;
        plan_cfg   = '{phase_ticks: PHASE_TICKS_RST, ack_timeout: ACK_TIMEOUT_RST};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_commands();
        test_write();
        test_read();
        test_ack_timeout();
        test_phase_ticks();
        test_full_rate();
        test_backpressure();
        test_random();

        // Drain, with a bound, then let the pipeline settle
        in_valid <= 1'b0;
        for (int k = 0; k < 5000 && bus_levels_due.size() != 0; k++) @(posedge clk);
        repeat (8) @(posedge clk);
        if (bus_levels_due.size() != 0) begin
            errors++;
            $display("%0t: results missing, expected %0d more, got none",
                     $time, bus_levels_due.size());
        end

        $display("Ran %0d ticks over %0d transfers with %0d config writes.",
                 items_sent, transfers, cfg_writes);
        $display("Checked %0d results: %0d bytes read, %0d acknowledge aborts, %0d errors.",
                 results_seen, bytes_read, aborts, errors);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Abort a hung run
    initial begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/i2cmra_pkg.sv
rtl/i2cmra_seq.sv
rtl/i2c_master_register_access.sv
test/tb_i2c_master_register_access.sv
